FILE: rtl/core/scheduled_message_timer_table_macros.svh
// Assertion macros for the timer table checker.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef SCHEDULED_MESSAGE_TIMER_TABLE_MACROS_SVH
`define SCHEDULED_MESSAGE_TIMER_TABLE_MACROS_SVH

// same-cycle implication
`define SMTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/smtt_pkg.sv
// Shared types and codes of the scheduled message timer table.
// Depends on nothing; used by the top level, smtt_head, the checker and the testbench.
package smtt_pkg;

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_SCHEDULE = 2'd1;
  localparam logic [1:0] CMD_CANCEL   = 2'd2;
  localparam logic [1:0] CMD_QUERY    = 2'd3;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_FIRED     = 3'd1;
  localparam logic [2:0] ST_SCHEDULED = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_CANCELLED = 3'd4;
  localparam logic [2:0] ST_QUERY     = 3'd5;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] msg_id;
    logic [31:0] msg_handle;
    logic        target_core;
    logic [23:0] delay_ticks;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] fired_id;
    logic [31:0] fired_handle;
    logic        fired_core;
    logic        found;
    logic [4:0]  busy_count;
    logic        last;
  } out_t;

  typedef struct packed {
    logic       scan;
    logic [1:0] cmd;
    logic       placed;
  } head_ctrl_t;

  typedef struct packed {
    logic fire;
    logic busy;
    logic hit;
    logic place;
  } head_flags_t;

endpackage

FILE: rtl/core/scheduled_message_timer_table.sv
// Top level of the scheduled message timer table: ring of slot cells, head update, control.
// Depends on smtt_pkg, smtt_cell and smtt_head.

// The slots form a ring that rotates one slot per cycle past a single head update unit
// while a command is in work, and every command makes one full rotation in the scan
// state. A schedule, cancel, query or a tick that fires nothing then has its one beat
// loaded into the output register from the finish state, and the next command is accepted
// once that beat is loaded. A tick that fires messages makes a second rotation to hand out
// one beat per fired slot in slot order; the ring holds while a fired beat waits, and the
// next command is accepted once that second rotation ends.
// No clearing pass is needed after reset.
module scheduled_message_timer_table #(
  parameter int SLOTS      = 16,
  parameter int DELAY_BITS = 24,
  parameter int ID_BITS    = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  smtt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output smtt_pkg::out_t out_data
);

  localparam int POS_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_FINISH
  } state_t;

  state_t                state_r, state_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]      busy_r, busy_nxt;
  logic [CNT_W-1:0]      fire_r, fire_nxt;
  logic                  hit_r, hit_nxt;
  logic                  placed_r, placed_nxt;
  logic                  out_valid_r, out_valid_nxt;
  smtt_pkg::out_t        out_data_r, out_data_nxt;

  logic [1:0]            cmd_r;
  logic [ID_BITS-1:0]    id_r;
  logic [31:0]           handle_r;
  logic                  core_r;
  logic [DELAY_BITS-1:0] delay_r;

  logic [ID_BITS+15:0]   in_id_ext;
  logic [DELAY_BITS+23:0] in_delay_ext;
  logic [DELAY_BITS-1:0] in_delay;

  logic                  busy_q   [SLOTS];
  logic                  pend_q   [SLOTS];
  logic [DELAY_BITS-1:0] cd_q     [SLOTS];
  logic [ID_BITS-1:0]    id_q     [SLOTS];
  logic [31:0]           handle_q [SLOTS];
  logic                  core_q   [SLOTS];

  logic                  h_busy, h_pend, h_core;
  logic [DELAY_BITS-1:0] h_cd;
  logic [ID_BITS-1:0]    h_id;
  logic [31:0]           h_handle;

  smtt_pkg::head_ctrl_t  ctrl;
  smtt_pkg::head_flags_t flags;

  logic                  shift;
  logic                  can_load;
  logic                  at_end;
  logic [CNT_W-1:0]      fire_sum;
  logic [CNT_W+4:0]      busy_ext;
  logic [ID_BITS+15:0]   fired_id_ext;

  assign in_id_ext    = {{ID_BITS{1'b0}}, in_data.msg_id};
  assign in_delay_ext = {{DELAY_BITS{1'b0}}, in_data.delay_ticks};
  assign in_delay     = in_delay_ext[DELAY_BITS-1:0];

  assign ctrl.scan   = (state_r == S_SCAN);
  assign ctrl.cmd    = cmd_r;
  assign ctrl.placed = placed_r;

  assign can_load = !out_valid_r || out_ready;
  assign at_end   = (pos_r == POS_W'(SLOTS - 1));
  assign fire_sum = fire_r + CNT_W'(flags.fire);
  assign busy_ext = {5'd0, busy_r};
  assign fired_id_ext = {16'd0, id_q[0]};

  always_comb begin
    case (state_r)
      S_SCAN:  shift = 1'b1;
      S_EMIT:  shift = !pend_q[0] || can_load;
      default: shift = 1'b0;
    endcase
  end

  smtt_head #(
    .DELAY_BITS (DELAY_BITS),
    .ID_BITS    (ID_BITS)
  ) u_head (
    .ctrl       (ctrl),
    .cmd_id     (id_r),
    .cmd_handle (handle_r),
    .cmd_core   (core_r),
    .cmd_delay  (delay_r),
    .busy_i     (busy_q[0]),
    .cd_i       (cd_q[0]),
    .id_i       (id_q[0]),
    .handle_i   (handle_q[0]),
    .core_i     (core_q[0]),
    .busy_o     (h_busy),
    .pend_o     (h_pend),
    .cd_o       (h_cd),
    .id_o       (h_id),
    .handle_o   (h_handle),
    .core_o     (h_core),
    .flags      (flags)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic                  nb_busy, nb_pend, nb_core;
    logic [DELAY_BITS-1:0] nb_cd;
    logic [ID_BITS-1:0]    nb_id;
    logic [31:0]           nb_handle;

    if (i == SLOTS - 1) begin : g_tail
      assign nb_busy   = h_busy;
      assign nb_pend   = h_pend;
      assign nb_cd     = h_cd;
      assign nb_id     = h_id;
      assign nb_handle = h_handle;
      assign nb_core   = h_core;
    end else begin : g_mid
      assign nb_busy   = busy_q[i+1];
      assign nb_pend   = pend_q[i+1];
      assign nb_cd     = cd_q[i+1];
      assign nb_id     = id_q[i+1];
      assign nb_handle = handle_q[i+1];
      assign nb_core   = core_q[i+1];
    end

    smtt_cell #(
      .DELAY_BITS (DELAY_BITS),
      .ID_BITS    (ID_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .busy_i   (nb_busy),
      .pend_i   (nb_pend),
      .cd_i     (nb_cd),
      .id_i     (nb_id),
      .handle_i (nb_handle),
      .core_i   (nb_core),
      .busy_o   (busy_q[i]),
      .pend_o   (pend_q[i]),
      .cd_o     (cd_q[i]),
      .id_o     (id_q[i]),
      .handle_o (handle_q[i]),
      .core_o   (core_q[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    busy_nxt      = busy_r;
    fire_nxt      = fire_r;
    hit_nxt       = hit_r;
    placed_nxt    = placed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt  = S_SCAN;
          pos_nxt    = '0;
          busy_nxt   = '0;
          fire_nxt   = '0;
          hit_nxt    = 1'b0;
          placed_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        busy_nxt   = busy_r + CNT_W'(flags.busy);
        fire_nxt   = fire_sum;
        hit_nxt    = hit_r || flags.hit;
        placed_nxt = placed_r || flags.place;
        pos_nxt    = pos_r + 1'b1;
        if (at_end) begin
          pos_nxt = '0;
          if (cmd_r == smtt_pkg::CMD_TICK && fire_sum != '0) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_EMIT: begin
        if (pend_q[0] && can_load) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt              = '0;
          out_data_nxt.status       = smtt_pkg::ST_FIRED;
          out_data_nxt.fired_id     = fired_id_ext[15:0];
          out_data_nxt.fired_handle = handle_q[0];
          out_data_nxt.fired_core   = core_q[0];
          out_data_nxt.busy_count   = busy_ext[4:0];
          out_data_nxt.last         = (fire_r == CNT_W'(1));
          fire_nxt                  = fire_r - 1'b1;
        end
        if (shift) begin
          pos_nxt = pos_r + 1'b1;
          if (at_end) begin
            pos_nxt   = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      S_FINISH: begin
        if (can_load) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt            = '0;
          out_data_nxt.busy_count = busy_ext[4:0];
          out_data_nxt.last       = 1'b1;
          case (cmd_r)
            smtt_pkg::CMD_TICK:     out_data_nxt.status = smtt_pkg::ST_IDLE;
            smtt_pkg::CMD_SCHEDULE: out_data_nxt.status =
                                      placed_r ? smtt_pkg::ST_SCHEDULED : smtt_pkg::ST_FULL;
            smtt_pkg::CMD_CANCEL:   out_data_nxt.status = smtt_pkg::ST_CANCELLED;
            default: begin
              out_data_nxt.status = smtt_pkg::ST_QUERY;
              out_data_nxt.found  = hit_r;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r      <= pos_nxt;
    busy_r     <= busy_nxt;
    fire_r     <= fire_nxt;
    hit_r      <= hit_nxt;
    placed_r   <= placed_nxt;
    out_data_r <= out_data_nxt;
    if (state_r == S_IDLE && in_valid) begin
      cmd_r    <= in_data.command;
      id_r     <= in_id_ext[ID_BITS-1:0];
      handle_r <= in_data.msg_handle;
      core_r   <= in_data.target_core;
      delay_r  <= (in_delay == '0) ? DELAY_BITS'(1) : in_delay;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/smtt_cell.sv
// One timer slot of the ring: busy and pending flags, countdown, id, handle, core.
// Depends on nothing; instantiated SLOTS times by the top level.
module smtt_cell #(
  parameter int DELAY_BITS = 24,
  parameter int ID_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift,
  input  logic                  busy_i,
  input  logic                  pend_i,
  input  logic [DELAY_BITS-1:0] cd_i,
  input  logic [ID_BITS-1:0]    id_i,
  input  logic [31:0]           handle_i,
  input  logic                  core_i,
  output logic                  busy_o,
  output logic                  pend_o,
  output logic [DELAY_BITS-1:0] cd_o,
  output logic [ID_BITS-1:0]    id_o,
  output logic [31:0]           handle_o,
  output logic                  core_o
);

  logic                  busy_r;
  logic                  pend_r;
  logic [DELAY_BITS-1:0] cd_r;
  logic [ID_BITS-1:0]    id_r;
  logic [31:0]           handle_r;
  logic                  core_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
    end else if (shift) begin
      busy_r <= busy_i;
      pend_r <= pend_i;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      cd_r     <= cd_i;
      id_r     <= id_i;
      handle_r <= handle_i;
      core_r   <= core_i;
    end
  end

  assign busy_o   = busy_r;
  assign pend_o   = pend_r;
  assign cd_o     = cd_r;
  assign id_o     = id_r;
  assign handle_o = handle_r;
  assign core_o   = core_r;

endmodule

FILE: rtl/core/smtt_head.sv
// Slot update applied at the head of the ring as each slot passes by.
// Depends on smtt_pkg for command codes and the control and flag structs.
module smtt_head #(
  parameter int DELAY_BITS = 24,
  parameter int ID_BITS    = 16
) (
  input  smtt_pkg::head_ctrl_t  ctrl,
  input  logic [ID_BITS-1:0]    cmd_id,
  input  logic [31:0]           cmd_handle,
  input  logic                  cmd_core,
  input  logic [DELAY_BITS-1:0] cmd_delay,
  input  logic                  busy_i,
  input  logic [DELAY_BITS-1:0] cd_i,
  input  logic [ID_BITS-1:0]    id_i,
  input  logic [31:0]           handle_i,
  input  logic                  core_i,
  output logic                  busy_o,
  output logic                  pend_o,
  output logic [DELAY_BITS-1:0] cd_o,
  output logic [ID_BITS-1:0]    id_o,
  output logic [31:0]           handle_o,
  output logic                  core_o,
  output smtt_pkg::head_flags_t flags
);

  logic [DELAY_BITS-1:0] cd_dec;
  logic                  id_match;

  assign cd_dec   = cd_i - 1'b1;
  assign id_match = busy_i && (id_i == cmd_id);

  always_comb begin
    busy_o   = busy_i;
    pend_o   = 1'b0;
    cd_o     = cd_i;
    id_o     = id_i;
    handle_o = handle_i;
    core_o   = core_i;
    flags    = '0;
    if (ctrl.scan) begin
      case (ctrl.cmd)
        smtt_pkg::CMD_TICK: begin
          if (busy_i) begin
            cd_o = cd_dec;
            if (cd_dec == '0) begin
              busy_o     = 1'b0;
              pend_o     = 1'b1;
              flags.fire = 1'b1;
            end
          end
        end
        smtt_pkg::CMD_SCHEDULE: begin
          if (!busy_i && !ctrl.placed) begin
            busy_o      = 1'b1;
            cd_o        = cmd_delay;
            id_o        = cmd_id;
            handle_o    = cmd_handle;
            core_o      = cmd_core;
            flags.place = 1'b1;
          end
        end
        smtt_pkg::CMD_CANCEL: begin
          if (id_match) begin
            busy_o = 1'b0;
          end
        end
        default: begin
          flags.hit = id_match;
        end
      endcase
      flags.busy = busy_o;
    end
  end

endmodule

FILE: rtl/core/smtt_checker.sv
// Port-level assertions for the timer table, bound to the top level.
// Depends on smtt_pkg and scheduled_message_timer_table_macros.svh.
`include "scheduled_message_timer_table_macros.svh"

module smtt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input smtt_pkg::out_t out_data
);

  `SMTT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output beat changed while stalled")
  `SMTT_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second command taken while one is in work")
  `SMTT_ASSERT_NOW(a_single_last, out_valid && out_data.status != smtt_pkg::ST_FIRED, out_data.last, "non-fired beat without last")
  `SMTT_ASSERT_NOW(a_fired_zero, out_valid && out_data.status != smtt_pkg::ST_FIRED, out_data.fired_id == 16'd0 && out_data.fired_handle == 32'd0 && !out_data.fired_core, "message fields set on a non-fired beat")

endmodule

bind scheduled_message_timer_table smtt_checker u_smtt_checker (.*);

FILE: verif/scheduled_message_timer_table_tb.sv
// Self-checking testbench for the scheduled message timer table.
// Depends on smtt_pkg and scheduled_message_timer_table; predicts every result beat
// from its own copy of the slot table and checks it against the block output.
module scheduled_message_timer_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  smtt_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  smtt_pkg::out_t out_data;

  logic        slot_busy   [SLOTS];
  logic [23:0] slot_count  [SLOTS];
  logic [15:0] slot_id     [SLOTS];
  logic [31:0] slot_handle [SLOTS];
  logic        slot_core   [SLOTS];

  smtt_pkg::out_t expected_beats[$];
  int   errors;
  int   idle_cycles;
  int   stall_left;
  bit   calm;
  bit   hold_request;

  logic [15:0] id_pool [6] = '{16'h0001, 16'h0002, 16'h00ff, 16'h8000, 16'hbeef, 16'hffff};

  scheduled_message_timer_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic smtt_pkg::in_t pack_command(logic [1:0] cmd, logic [15:0] id,
                                                 logic [31:0] handle, logic core,
                                                 logic [23:0] delay);
    smtt_pkg::in_t c;
    c.command     = cmd;
    c.msg_id      = id;
    c.msg_handle  = handle;
    c.target_core = core;
    c.delay_ticks = delay;
    return c;
  endfunction

  function automatic logic [15:0] pick_id();
    if ($urandom_range(0, 99) < 80) return id_pool[$urandom_range(0, 5)];
    return 16'($urandom);
  endfunction

  function automatic smtt_pkg::in_t random_command();
    int          r;
    logic [23:0] delay;
    r = $urandom_range(0, 99);
    if (r < 40)
      return pack_command(smtt_pkg::CMD_TICK, 16'($urandom), $urandom, 1'($urandom),
                          24'($urandom));
    if (r < 75) begin
      r = $urandom_range(0, 99);
      if (r < 70)      delay = 24'($urandom_range(0, 12));
      else if (r < 90) delay = 24'($urandom_range(13, 60));
      else             delay = 24'($urandom);
      return pack_command(smtt_pkg::CMD_SCHEDULE, pick_id(), $urandom, 1'($urandom), delay);
    end
    if (r < 88)
      return pack_command(smtt_pkg::CMD_CANCEL, pick_id(), $urandom, 1'($urandom),
                          24'($urandom));
    return pack_command(smtt_pkg::CMD_QUERY, pick_id(), $urandom, 1'($urandom), 24'($urandom));
  endfunction

  function automatic void advance_table(smtt_pkg::in_t c);
    smtt_pkg::out_t beats[$];
    smtt_pkg::out_t b;
    int   busy;
    b = '0;
    case (c.command)
      smtt_pkg::CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy[i]) begin
            slot_count[i] = slot_count[i] - 24'd1;
            if (slot_count[i] == '0) begin
              b              = '0;
              b.status       = smtt_pkg::ST_FIRED;
              b.fired_id     = slot_id[i];
              b.fired_handle = slot_handle[i];
              b.fired_core   = slot_core[i];
              beats.push_back(b);
              slot_busy[i] = 1'b0;
            end
          end
        end
        if (beats.size() == 0) begin
          b        = '0;
          b.status = smtt_pkg::ST_IDLE;
          beats.push_back(b);
        end
      end
      smtt_pkg::CMD_SCHEDULE: begin
        b.status = smtt_pkg::ST_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_busy[i] && b.status == smtt_pkg::ST_FULL) begin
            slot_busy[i]   = 1'b1;
            slot_count[i]  = (c.delay_ticks == '0) ? 24'd1 : c.delay_ticks;
            slot_id[i]     = c.msg_id;
            slot_handle[i] = c.msg_handle;
            slot_core[i]   = c.target_core;
            b.status       = smtt_pkg::ST_SCHEDULED;
          end
        end
        beats.push_back(b);
      end
      smtt_pkg::CMD_CANCEL: begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_busy[i] && slot_id[i] == c.msg_id) slot_busy[i] = 1'b0;
        b.status = smtt_pkg::ST_CANCELLED;
        beats.push_back(b);
      end
      default: begin
        b.status = smtt_pkg::ST_QUERY;
        for (int i = 0; i < SLOTS; i++)
          if (slot_busy[i] && slot_id[i] == c.msg_id) b.found = 1'b1;
        beats.push_back(b);
      end
    endcase
    busy = 0;
    for (int i = 0; i < SLOTS; i++) busy += int'(slot_busy[i]);
    foreach (beats[k]) begin
      beats[k].busy_count = 5'(busy);
      beats[k].last       = (k == beats.size() - 1);
      expected_beats.push_back(beats[k]);
    end
  endfunction

  task automatic offer_command(smtt_pkg::in_t c);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = c;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    advance_table(c);
    @(negedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_beats
    smtt_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("beat with nothing expected: %p", out_data);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        check_field("status",       32'(want.status),       32'(out_data.status));
        check_field("fired_id",     32'(want.fired_id),     32'(out_data.fired_id));
        check_field("fired_handle", want.fired_handle,      out_data.fired_handle);
        check_field("fired_core",   32'(want.fired_core),   32'(out_data.fired_core));
        check_field("found",        32'(want.found),        32'(out_data.found));
        check_field("busy_count",   32'(want.busy_count),   32'(out_data.busy_count));
        check_field("last",         32'(want.last),         32'(out_data.last));
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      out_ready    = 1'b0;
      stall_left   = HOLD_CYCLES - 1;
    end else if (calm || $urandom_range(0, 99) < 70) begin
      out_ready = 1'b1;
    end else begin
      out_ready  = 1'b0;
      stall_left = pick_gap() - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_basic_commands();
    offer_command(pack_command(smtt_pkg::CMD_TICK, 16'h0000, 32'h0, 1'b0, 24'h0));
    offer_command(pack_command(smtt_pkg::CMD_QUERY, 16'h0000, 32'h0, 1'b0, 24'h0));
    offer_command(pack_command(smtt_pkg::CMD_CANCEL, 16'hffff, 32'hffffffff, 1'b1,
                               24'hffffff));
    offer_command(pack_command(smtt_pkg::CMD_SCHEDULE, 16'hffff, 32'hffffffff, 1'b1, 24'h0));
    offer_command(pack_command(smtt_pkg::CMD_TICK, 16'hffff, 32'hffffffff, 1'b1, 24'hffffff));
    offer_command(pack_command(smtt_pkg::CMD_SCHEDULE, 16'h0000, 32'h0, 1'b0, 24'hffffff));
    offer_command(pack_command(smtt_pkg::CMD_SCHEDULE, 16'h1234, 32'ha5a5a5a5, 1'b1, 24'd2));
    offer_command(pack_command(smtt_pkg::CMD_SCHEDULE, 16'h1234, 32'h5a5a5a5a, 1'b0, 24'd2));
    offer_command(pack_command(smtt_pkg::CMD_QUERY, 16'h1234, 32'h0, 1'b0, 24'h0));
    offer_command(pack_command(smtt_pkg::CMD_TICK, 16'h0, 32'h0, 1'b0, 24'h0));
    offer_command(pack_command(smtt_pkg::CMD_TICK, 16'h0, 32'h0, 1'b0, 24'h0));
    offer_command(pack_command(smtt_pkg::CMD_QUERY, 16'h0000, 32'h0, 1'b0, 24'h0));
    offer_command(pack_command(smtt_pkg::CMD_CANCEL, 16'h0000, 32'h0, 1'b0, 24'h0));
    offer_command(pack_command(smtt_pkg::CMD_QUERY, 16'h0000, 32'h0, 1'b0, 24'h0));
  endtask

  task automatic test_full_table();
    for (int i = 0; i < SLOTS; i++)
      offer_command(pack_command(smtt_pkg::CMD_SCHEDULE, 16'(i), $urandom, 1'(i),
                                 24'(i % 2)));
    offer_command(pack_command(smtt_pkg::CMD_SCHEDULE, 16'h4242, 32'h12345678, 1'b1, 24'd1));
    offer_command(pack_command(smtt_pkg::CMD_TICK, 16'h0, 32'h0, 1'b0, 24'h0));
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 400; n++) begin
      if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      offer_command(random_command());
    end
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    repeat (12) offer_command(random_command());
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    errors       = 0;
    idle_cycles  = 0;
    stall_left   = 0;
    calm         = 1'b0;
    hold_request = 1'b0;
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_basic_commands();
    test_full_table();
    test_random_traffic();
    test_backpressure();

    in_valid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/smtt_pkg.sv
rtl/core/smtt_cell.sv
rtl/core/smtt_head.sv
rtl/core/scheduled_message_timer_table.sv
rtl/core/smtt_checker.sv
verif/scheduled_message_timer_table_tb.sv
